@@ hw/rtl/plte_pkg.sv @@
// Shared constants, request and status codes, and the RAM port struct for
// the positional list table engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plte_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int REQ_W  = 3;
  localparam int STAT_W = 3;

  localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DUMP    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd4;

  localparam logic [DATA_W-1:0] UPD_ADD = DATA_W'(5);

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    word_t            wr_data;
  } ram_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/plte_ram.sv @@
// Element store: one write port and one read port with registered read data.
// Depends on plte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plte_ram
  import plte_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output word_t         rd_data
);

  word_t mem [DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/plte_unit.sv @@
// Shared datapath unit: key compare and the update rewrite of one word.
// Depends on plte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plte_unit
  import plte_pkg::*;
(
  input  wire word_t a,
  input  wire word_t key,
  input  wire logic  odd,
  output logic       eq,
  output word_t      upd
);

  assign eq  = (a == key);
  // Odd positions double, even positions add five; both wrap.
  assign upd = odd ? {a[DATA_W-2:0], 1'b0} : (a + UPD_ADD);

endmodule

`default_nettype wire

@@ hw/rtl/positional_list_table_engine.sv @@
// Top level of the positional list table engine: request sequencer, result
// register and the instances of the element store and the datapath unit.
// Depends on plte_pkg, plte_ram and plte_unit.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Requests arrive on the in_ channel (valid/ready); one transfer carries a
// request type, a list position and a value. The block serves one request at
// a time and drops in_ready from the transfer until its work is finished.
// Results leave on the out_ channel from an output register; every request
// gives one result, except dump, which gives one per entry (one for an empty
// list) with out_last_of_run set on the final one. Unknown request types are
// dropped without a result.
// Search, insert, delete, update and dump walk the element store through its
// single read and single write port, one entry per cycle (a dump only while
// the output slot is free), so the cost follows the list count n; reverse
// swaps one pair per pass through S_RV_RB, S_RV_WA and S_RV_WB. Every defined
// request but a dump then loads the result register in its result step; a
// rejected request goes there at once. Dump loads each entry straight into
// the output register. in_ready returns in the cycle after the work ends. A
// stalled receiver holds the result register; a dump then pauses in place and
// resumes when the pending transfer completes, and other requests wait in
// their result step. Reset clears the count, the sequencer and the output
// valid. The store itself is not cleared; entries are only read after they
// were written.

module positional_list_table_engine
  import plte_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [REQ_W-1:0]   in_req_type,
  input  wire logic [CNT_W-1:0]   in_position,
  input  wire logic signed [DATA_W-1:0] in_item_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [STAT_W-1:0]       out_status,
  output logic [IDX_W-1:0]        out_found_index,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic [CNT_W-1:0]        out_element_count,
  output logic                    out_last_of_run
);

  localparam int SW = 4;
  localparam logic [SW-1:0] S_IDLE  = 4'd0;
  localparam logic [SW-1:0] S_SRCH  = 4'd1;
  localparam logic [SW-1:0] S_INS   = 4'd2;
  localparam logic [SW-1:0] S_DEL   = 4'd3;
  localparam logic [SW-1:0] S_UPD   = 4'd4;
  localparam logic [SW-1:0] S_DUMP  = 4'd5;
  localparam logic [SW-1:0] S_RV_RB = 4'd6;
  localparam logic [SW-1:0] S_RV_WA = 4'd7;
  localparam logic [SW-1:0] S_RV_WB = 4'd8;
  localparam logic [SW-1:0] S_RESP  = 4'd9;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  // Control state.
  logic [SW-1:0]    state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pipe_v_r, pipe_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Walk pointers and request operands.
  logic [CNT_W-1:0] p_r, p_nxt;           // next entry to read, or one above it on insert (front side)
  logic [IDX_W-1:0] q_r, q_nxt;           // back side of a reverse
  logic [IDX_W-1:0] pipe_idx_r, pipe_idx_nxt; // index of the word in rd_data
  logic [CNT_W-1:0] pos_r, pos_nxt;
  word_t            key_r, key_nxt;
  word_t            tmp_r, tmp_nxt;

  // Pending single result.
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  word_t             res_value_r, res_value_nxt;

  // Output register payload.
  logic [STAT_W-1:0] o_status_r, o_status_nxt;
  logic [IDX_W-1:0]  o_idx_r, o_idx_nxt;
  word_t             o_value_r, o_value_nxt;
  logic [CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic              o_last_r, o_last_nxt;

  ram_req_t ram_req;
  word_t    rd_data;
  logic     unit_eq;
  word_t    unit_upd;

  logic in_fire;
  logic slot_free;
  logic [CNT_W-1:0] p_inc, p_dec;
  logic [IDX_W-1:0] q_dec;

  plte_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  plte_unit u_unit (
    .a   (rd_data),
    .key (key_r),
    .odd (pipe_idx_r[0]),
    .eq  (unit_eq),
    .upd (unit_upd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign p_inc     = p_r + CNT_ONE;
  assign p_dec     = p_r - CNT_ONE;
  assign q_dec     = q_r - IDX_ONE;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pipe_v_nxt     = pipe_v_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    pipe_idx_nxt   = pipe_idx_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    tmp_nxt        = tmp_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_status_nxt   = o_status_r;
    o_idx_nxt      = o_idx_r;
    o_value_nxt    = o_value_r;
    o_cnt_nxt      = o_cnt_r;
    o_last_nxt     = o_last_r;
    ram_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pos_nxt        = in_position;
          key_nxt        = in_item_value;
          p_nxt          = '0;
          pipe_v_nxt     = 1'b0;
          res_status_nxt = ST_OK;
          res_idx_nxt    = '0;
          res_value_nxt  = '0;
          tmp_nxt        = '0;
          unique case (in_req_type)
            REQ_SEARCH: state_nxt = S_SRCH;
            REQ_INSERT: begin
              if (cnt_r == CNT_FULL) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_RESP;
              end else if (in_position > cnt_r) begin
                res_status_nxt = ST_BAD_POS;
                state_nxt      = S_RESP;
              end else begin
                p_nxt     = cnt_r;
                state_nxt = S_INS;
              end
            end
            REQ_DELETE: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESP;
              end else if (in_position >= cnt_r) begin
                res_status_nxt = ST_BAD_POS;
                state_nxt      = S_RESP;
              end else begin
                p_nxt     = in_position;
                state_nxt = S_DEL;
              end
            end
            REQ_REVERSE: begin
              if (cnt_r > CNT_ONE) begin
                // Front pointer starts at zero, back pointer at the last entry.
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = '0;
                q_nxt           = cnt_r[IDX_W-1:0] - IDX_ONE;
                state_nxt       = S_RV_RB;
              end else begin
                state_nxt = S_RESP;
              end
            end
            REQ_UPDATE: state_nxt = S_UPD;
            REQ_DUMP: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_DUMP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_SRCH: begin
        if (pipe_v_r && unit_eq) begin
          res_idx_nxt = pipe_idx_r;
          state_nxt   = S_RESP;
        end else if (p_r < cnt_r) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = p_r[IDX_W-1:0];
          pipe_idx_nxt    = p_r[IDX_W-1:0];
          pipe_v_nxt      = 1'b1;
          p_nxt           = p_inc;
        end else begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end
      end

      S_INS: begin
        // Walk down from the top; each word read moves up by one.
        if (pipe_v_r) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = pipe_idx_r + IDX_ONE;
          ram_req.wr_data = rd_data;
        end
        if (p_r > pos_r) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = p_dec[IDX_W-1:0];
          pipe_idx_nxt    = p_dec[IDX_W-1:0];
          pipe_v_nxt      = 1'b1;
          p_nxt           = p_dec;
        end else begin
          pipe_v_nxt = 1'b0;
          if (!pipe_v_r) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_r[IDX_W-1:0];
            ram_req.wr_data = key_r;
            cnt_nxt         = cnt_r + CNT_ONE;
            state_nxt       = S_RESP;
          end
        end
      end

      S_DEL: begin
        // The first word read is the removed one; the rest move down by one.
        if (pipe_v_r) begin
          if ({1'b0, pipe_idx_r} == pos_r) begin
            tmp_nxt = rd_data;
          end else begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pipe_idx_r - IDX_ONE;
            ram_req.wr_data = rd_data;
          end
        end
        if (p_r < cnt_r) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = p_r[IDX_W-1:0];
          pipe_idx_nxt    = p_r[IDX_W-1:0];
          pipe_v_nxt      = 1'b1;
          p_nxt           = p_inc;
        end else begin
          pipe_v_nxt = 1'b0;
          if (!pipe_v_r) begin
            cnt_nxt       = cnt_r - CNT_ONE;
            res_value_nxt = tmp_r;
            state_nxt     = S_RESP;
          end
        end
      end

      S_UPD: begin
        if (pipe_v_r) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = pipe_idx_r;
          ram_req.wr_data = unit_upd;
        end
        if (p_r < cnt_r) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = p_r[IDX_W-1:0];
          pipe_idx_nxt    = p_r[IDX_W-1:0];
          pipe_v_nxt      = 1'b1;
          p_nxt           = p_inc;
        end else begin
          pipe_v_nxt = 1'b0;
          if (!pipe_v_r) begin
            state_nxt = S_RESP;
          end
        end
      end

      S_DUMP: begin
        // A word waiting in rd_data holds until the output slot frees up.
        if (!pipe_v_r || slot_free) begin
          if (pipe_v_r) begin
            out_valid_nxt = 1'b1;
            o_status_nxt  = ST_OK;
            o_idx_nxt     = '0;
            o_value_nxt   = rd_data;
            o_cnt_nxt     = cnt_r;
            o_last_nxt    = (({1'b0, pipe_idx_r} + CNT_ONE) == cnt_r);
          end
          if (p_r < cnt_r) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = p_r[IDX_W-1:0];
            pipe_idx_nxt    = p_r[IDX_W-1:0];
            pipe_v_nxt      = 1'b1;
            p_nxt           = p_inc;
          end else begin
            pipe_v_nxt = 1'b0;
            if (!pipe_v_r) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      S_RV_RB: begin
        // rd_data holds the front word; fetch the back word.
        tmp_nxt         = rd_data;
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = q_r;
        state_nxt       = S_RV_WA;
      end

      S_RV_WA: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = p_r[IDX_W-1:0];
        ram_req.wr_data = rd_data;
        state_nxt       = S_RV_WB;
      end

      S_RV_WB: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = q_r;
        ram_req.wr_data = tmp_r;
        p_nxt           = p_inc;
        q_nxt           = q_dec;
        if (p_inc < {1'b0, q_dec}) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = p_inc[IDX_W-1:0];
          state_nxt       = S_RV_RB;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_status_r;
          o_idx_nxt     = res_idx_r;
          o_value_nxt   = res_value_r;
          o_cnt_nxt     = cnt_r;
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    pipe_idx_r   <= pipe_idx_nxt;
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    tmp_r        <= tmp_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_value_r  <= res_value_nxt;
    o_status_r   <= o_status_nxt;
    o_idx_r      <= o_idx_nxt;
    o_value_r    <= o_value_nxt;
    o_cnt_r      <= o_cnt_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_found_index   = o_idx_r;
  assign out_result_value  = o_value_r;
  assign out_element_count = o_cnt_r;
  assign out_last_of_run   = o_last_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("element count above depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_req.wr_en)
    else $error("store written while idle");

  a_full_insert_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req_type == REQ_INSERT && cnt_r == CNT_FULL) |=>
      (cnt_r == $past(cnt_r)))
    else $error("count changed on insert into full list");

  a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
    else $error("read and write at the same store address");
`endif

endmodule

`default_nettype wire

@@ test/tb_positional_list_table_engine.sv @@
// Self-checking testbench for the positional list table engine: directed table plus
// random request streams, checked against an in-bench model of the list.
// Depends on plte_pkg and the positional_list_table_engine RTL.
`timescale 1ns / 1ps

module tb_positional_list_table_engine;
  import plte_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int LIMIT_CYCLES   = 400000;
  localparam int RX_HOLD_CYCLES = 300;
  // Margin after the last result, meant to cover any request still in flight.
  localparam int SETTLE_CYCLES  = 150;

  // Request codes that the block does not define; it must drop them silently.
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  found_index;
    word_t             value;
    logic [CNT_W-1:0]  count;
    logic              last;
  } list_result_t;

  // One row of the directed table. When has_fixed is set, the typed-in result
  // is what the block must return, and the list model only tracks state.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [CNT_W-1:0] pos;
    word_t            value;
    logic             has_fixed;
    list_result_t     fixed;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid;
  logic                     in_ready;
  logic [REQ_W-1:0]         in_req_type;
  logic [CNT_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_item_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        out_status;
  logic [IDX_W-1:0]         out_found_index;
  logic signed [DATA_W-1:0] out_result_value;
  logic [CNT_W-1:0]         out_element_count;
  logic                     out_last_of_run;

  // Shadow copy of the list, updated when a request transfer is accepted.
  word_t        list_words [DEPTH];
  int           list_len;
  list_result_t list_model_out[$];
  list_result_t expected_results[$];
  stim_row_t    directed_rows[$];

  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_left = 0;

  positional_list_table_engine i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_index   (out_found_index),
    .out_result_value  (out_result_value),
    .out_element_count (out_element_count),
    .out_last_of_run   (out_last_of_run)
  );

  always #(CLK_HALF) clk = ~clk;

  // A hard limit on run length catches a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Queues one result of the list model. The count is always the count after
  // the request, so callers update list_len first.
  function automatic void note_result(input logic [STAT_W-1:0] status, input int idx,
                                      input word_t value, input bit last);
    list_result_t r;
    r.status      = status;
    r.found_index = IDX_W'(idx);
    r.value       = value;
    r.count       = CNT_W'(list_len);
    r.last        = last;
    list_model_out.push_back(r);
  endfunction

  // Applies one request to the shadow list and queues the results that the
  // block must produce for it.
  function automatic void list_apply_request(input logic [REQ_W-1:0] req,
                                             input logic [CNT_W-1:0] pos, input word_t val);
    int    n;
    int    hit;
    word_t tmp;
    n   = list_len;
    hit = -1;
    case (req)
      REQ_SEARCH: begin
        for (int i = 0; i < n; i++)
          if (hit < 0 && list_words[i] == val) hit = i;
        if (hit >= 0) note_result(ST_OK, hit, '0, 1'b1);
        else note_result(ST_NOT_FOUND, 0, '0, 1'b1);
      end
      REQ_INSERT: begin
        // A full list is reported before the position is looked at.
        if (n >= DEPTH) note_result(ST_FULL, 0, '0, 1'b1);
        else if (int'(pos) > n) note_result(ST_BAD_POS, 0, '0, 1'b1);
        else begin
          for (int i = n; i > int'(pos); i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          list_len = n + 1;
          note_result(ST_OK, 0, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        // An empty list is reported before the position is looked at.
        if (n == 0) note_result(ST_EMPTY, 0, '0, 1'b1);
        else if (int'(pos) >= n) note_result(ST_BAD_POS, 0, '0, 1'b1);
        else begin
          tmp = list_words[pos];
          for (int i = int'(pos); i + 1 < n; i++) list_words[i] = list_words[i+1];
          list_len = n - 1;
          note_result(ST_OK, 0, tmp, 1'b1);
        end
      end
      REQ_REVERSE: begin
        for (int i = 0; i < n / 2; i++) begin
          tmp               = list_words[i];
          list_words[i]     = list_words[n-1-i];
          list_words[n-1-i] = tmp;
        end
        note_result(ST_OK, 0, '0, 1'b1);
      end
      REQ_UPDATE: begin
        // Odd slots double, even slots gain five; both wrap at the word width.
        for (int i = 0; i < n; i++)
          if (i % 2 == 1) list_words[i] = list_words[i] << 1;
          else list_words[i] = list_words[i] + UPD_ADD;
        note_result(ST_OK, 0, '0, 1'b1);
      end
      REQ_DUMP: begin
        if (n == 0) note_result(ST_EMPTY, 0, '0, 1'b1);
        else
          for (int i = 0; i < n; i++) note_result(ST_OK, 0, list_words[i], i == n - 1);
      end
      default: ;  // Spare codes leave the list alone and produce nothing.
    endcase
  endfunction

  // Offers one request and waits for its transfer. The idle gap in front of
  // the request is drawn here, so in_valid sees only one assignment per edge.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [CNT_W-1:0] pos,
                              input word_t val, input logic has_fixed = 1'b0,
                              input list_result_t fixed = '0);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_position   <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    list_model_out.delete();
    list_apply_request(req, pos, val);
    if (has_fixed) expected_results.push_back(fixed);
    else foreach (list_model_out[k]) expected_results.push_back(list_model_out[k]);
  endtask

  // Takes the sender off the bus and waits until every queued result has come
  // out, plus a margin for work that produces no result.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Values lean toward small numbers, the word extremes and words already in
  // the list, so that searches hit and update wraps.
  function automatic word_t pick_value();
    case ($urandom_range(0, 3))
      0: return word_t'($urandom_range(0, 15));
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '1;
          default: return '0;
        endcase
      end
      default: return (list_len > 0) ? list_words[$urandom_range(0, list_len - 1)] : $urandom;
    endcase
  endfunction

  // Random request mix. Most positions are legal for the current length, and
  // one in ten is any 7-bit value to reach the bad-position paths.
  task automatic random_requests(input int num);
    logic [REQ_W-1:0] req;
    logic [CNT_W-1:0] pos;
    int               roll;
    for (int k = 0; k < num; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) req = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
      else if (roll < 22) req = REQ_SEARCH;
      else if (roll < 55) req = REQ_INSERT;
      else if (roll < 77) req = REQ_DELETE;
      else if (roll < 84) req = REQ_REVERSE;
      else if (roll < 91) req = REQ_UPDATE;
      else req = REQ_DUMP;
      // Keep the list from sticking at full.
      if (req == REQ_INSERT && list_len > 40 && $urandom_range(0, 1)) req = REQ_DELETE;
      if ($urandom_range(0, 9) == 0) pos = CNT_W'($urandom_range(0, 127));
      else if (req == REQ_INSERT) pos = CNT_W'($urandom_range(0, list_len));
      else pos = (list_len > 0) ? CNT_W'($urandom_range(0, list_len - 1)) : '0;
      send_request(req, pos, pick_value());
    end
  endtask

  function automatic stim_row_t row_free(input logic [REQ_W-1:0] req,
                                         input logic [CNT_W-1:0] pos, input word_t val);
    stim_row_t r;
    r           = '0;
    r.req       = req;
    r.pos       = pos;
    r.value     = val;
    return r;
  endfunction

  // A row whose single result is typed in: found index is zero, last is set.
  function automatic stim_row_t row_fixed(input logic [REQ_W-1:0] req,
                                          input logic [CNT_W-1:0] pos, input word_t val,
                                          input logic [STAT_W-1:0] status, input word_t rv,
                                          input int cnt);
    stim_row_t r;
    r              = row_free(req, pos, val);
    r.has_fixed    = 1'b1;
    r.fixed.status = status;
    r.fixed.value  = rv;
    r.fixed.count  = CNT_W'(cnt);
    r.fixed.last   = 1'b1;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Every result transfer is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d, value %0h",
               out_status, out_result_value);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("found_index", 32'(want.found_index), 32'(out_found_index));
        check_field("result_value", want.value, out_result_value);
        check_field("element_count", 32'(want.count), 32'(out_element_count));
        check_field("last_of_run", 32'(want.last), 32'(out_last_of_run));
      end
    end
  end

  // Receiver. A pending hold-off keeps out_ready low for that many cycles so
  // the output register fills and the block has to drop in_ready.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    in_valid      = 1'b0;
    in_req_type   = REQ_SEARCH;
    in_position   = '0;
    in_item_value = '0;
    list_len      = 0;

    // Directed table. Typed-in rows cover the empty list, the bad positions
    // and inserts whose count is obvious; the rest go through the model.
    directed_rows.push_back(row_fixed(REQ_SEARCH, 0, 0, ST_NOT_FOUND, 0, 0));
    directed_rows.push_back(row_fixed(REQ_DELETE, 0, 0, ST_EMPTY, 0, 0));
    directed_rows.push_back(row_fixed(REQ_DUMP, 0, 0, ST_EMPTY, 0, 0));
    directed_rows.push_back(row_fixed(REQ_REVERSE, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(row_fixed(REQ_UPDATE, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(row_fixed(REQ_INSERT, 1, 5, ST_BAD_POS, 0, 0));
    directed_rows.push_back(row_fixed(REQ_INSERT, 127, 5, ST_BAD_POS, 0, 0));
    directed_rows.push_back(row_fixed(REQ_INSERT, 0, 32'h7FFF_FFFF, ST_OK, 0, 1));
    directed_rows.push_back(row_fixed(REQ_INSERT, 1, 32'h8000_0000, ST_OK, 0, 2));
    directed_rows.push_back(row_fixed(REQ_INSERT, 0, 32'hFFFF_FFFF, ST_OK, 0, 3));
    directed_rows.push_back(row_fixed(REQ_INSERT, 3, 0, ST_OK, 0, 4));
    directed_rows.push_back(row_free(REQ_SEARCH, 0, 32'h8000_0000));
    directed_rows.push_back(row_fixed(REQ_SEARCH, 127, 12345, ST_NOT_FOUND, 0, 4));
    directed_rows.push_back(row_free(REQ_DUMP, 0, 0));
    directed_rows.push_back(row_free(REQ_UPDATE, 0, 0));
    directed_rows.push_back(row_free(REQ_DUMP, 0, 0));
    directed_rows.push_back(row_free(REQ_REVERSE, 0, 0));
    directed_rows.push_back(row_free(REQ_DUMP, 0, 0));
    directed_rows.push_back(row_fixed(REQ_DELETE, 4, 0, ST_BAD_POS, 0, 4));
    directed_rows.push_back(row_fixed(REQ_DELETE, 127, 0, ST_BAD_POS, 0, 4));
    directed_rows.push_back(row_free(REQ_SPARE_A, 7'h55, 32'hA5A5_A5A5));
    directed_rows.push_back(row_free(REQ_SPARE_B, 7'h2A, 32'h5A5A_5A5A));
    directed_rows.push_back(row_free(REQ_DELETE, 3, 0));
    directed_rows.push_back(row_free(REQ_REVERSE, 0, 0));
    directed_rows.push_back(row_free(REQ_INSERT, 3, 32'h55AA_00FF));
    directed_rows.push_back(row_free(REQ_DELETE, 0, 0));
    directed_rows.push_back(row_free(REQ_DUMP, 0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one: sender mostly busy, receiver mostly stalling.
    tx_idle_pct = 10;
    rx_idle_pct = 65;
    foreach (directed_rows[k])
      send_request(directed_rows[k].req, directed_rows[k].pos, directed_rows[k].value,
                   directed_rows[k].has_fixed, directed_rows[k].fixed);
    random_requests(10);
    // Long receiver hold-off while the sender keeps offering requests.
    rx_hold_left = RX_HOLD_CYCLES;
    random_requests(70);
    wait_for_results();

    // Phase two: the roles swap. Fill the list to the top, then poke the full
    // cases: inserts into the full list at the front and at the end, and a dump of all
    // entries stresses the result path.
    tx_idle_pct = 65;
    rx_idle_pct = 10;
    while (list_len < DEPTH)
      send_request(REQ_INSERT, CNT_W'($urandom_range(0, list_len)), pick_value());
    send_request(REQ_INSERT, 0, 32'h1234_5678);
    send_request(REQ_INSERT, 7'd64, 32'h1234_5678);
    send_request(REQ_DUMP, 0, 0);
    send_request(REQ_DELETE, 7'd64, 0);
    send_request(REQ_UPDATE, 0, 0);
    send_request(REQ_REVERSE, 0, 0);
    random_requests(60);
    wait_for_results();

    // Phase three: no idling on either side. Drain the list completely, try
    // one more delete on the empty list, then finish with random traffic.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (list_len > 0)
      send_request(REQ_DELETE, CNT_W'($urandom_range(0, list_len - 1)), $urandom);
    send_request(REQ_DELETE, 0, 0);
    random_requests(80);
    wait_for_results();

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ positional_list_table_engine.f @@
hw/rtl/plte_pkg.sv
hw/rtl/plte_ram.sv
hw/rtl/plte_unit.sv
hw/rtl/positional_list_table_engine.sv
test/tb_positional_list_table_engine.sv
